/* src/sha1_pkg.sv */
`default_nettype none

package sha1_pkg;

   localparam int unsigned ROUND_COUNT = 80;
   localparam int unsigned WINDOW_DEPTH = 16;
   localparam int unsigned CHAIN_DEPTH = 5;

   localparam logic [31:0] SHA1_IV [0:CHAIN_DEPTH-1] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   // byte position where the 64-bit length field starts (448 bits)
   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
   localparam logic [6:0] ROUND_LAST = 7'(ROUND_COUNT - 1);
   localparam logic [2:0] WORD_LAST = 3'(CHAIN_DEPTH - 1);

   // byte source for a block write
   localparam logic [1:0] SRC_MSG  = 2'd0;
   localparam logic [1:0] SRC_MARK = 2'd1;
   localparam logic [1:0] SRC_ZERO = 2'd2;
   localparam logic [1:0] SRC_LEN  = 2'd3;

   typedef struct packed {
      logic       wr_en;
      logic [1:0] wr_src;
      logic       wr_at_pad;
      logic       cnt_inc;
      logic       pad_set;
      logic       pad_inc;
      logic       vars_load;
      logic       round_en;
      logic       chain_add;
      logic       out_next;
      logic       clear;
   } sha1_cmd_type;

   typedef struct packed {
      logic cnt_pos_last;
      logic pad_pos_last;
      logic pad_at_len;
      logic round_last;
      logic word_last;
   } sha1_sts_type;

endpackage

`default_nettype wire

/* src/sha1_dp.sv */
`default_nettype none

module sha1_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sha1_pkg::sha1_cmd_type cmd,
   output sha1_pkg::sha1_sts_type     sts,
   input  wire logic [7:0]            in_byte,
   output logic [31:0]                out_word,
   output logic [2:0]                 out_index
);
   import sha1_pkg::*;

   logic [31:0] w_ff     [0:WINDOW_DEPTH-1];
   logic [31:0] w_in     [0:WINDOW_DEPTH-1];
   logic [31:0] vars_ff  [0:CHAIN_DEPTH-1];
   logic [31:0] vars_in  [0:CHAIN_DEPTH-1];
   logic [31:0] chain_ff [0:CHAIN_DEPTH-1];
   logic [31:0] chain_in [0:CHAIN_DEPTH-1];
   logic [60:0] count_ff, count_in;
   logic [5:0]  pad_ff, pad_in;
   logic [6:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;

   logic [5:0]  wr_addr;
   logic [63:0] len_bits;
   logic [7:0]  len_byte;
   logic [7:0]  wr_byte;
   logic [31:0] w_next;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] temp;
   logic [31:0] va, vb, vc, vd, ve;

   assign wr_addr  = cmd.wr_at_pad ? pad_ff : count_ff[5:0];
   assign len_bits = {count_ff, 3'b000};
   assign len_byte = len_bits[{~wr_addr[2:0], 3'b000} +: 8];

   always_comb begin
      unique case (cmd.wr_src)
         SRC_MSG:  wr_byte = in_byte;
         SRC_MARK: wr_byte = 8'h80;
         SRC_ZERO: wr_byte = 8'h00;
         SRC_LEN:  wr_byte = len_byte;
         default:  wr_byte = 8'h00;
      endcase
   end

   assign va = vars_ff[0];
   assign vb = vars_ff[1];
   assign vc = vars_ff[2];
   assign vd = vars_ff[3];
   assign ve = vars_ff[4];

   // next schedule word, window holds w[t..t+15]
   assign w_next = {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]} << 1
                 | {31'd0, w_ff[13][31] ^ w_ff[8][31] ^ w_ff[2][31] ^ w_ff[0][31]};

   always_comb begin
      priority if (round_ff < 7'd20) begin
         f_val = (vb & vc) | (~vb & vd);
         k_val = K_ROUND0;
      end else if (round_ff < 7'd40) begin
         f_val = vb ^ vc ^ vd;
         k_val = K_ROUND1;
      end else if (round_ff < 7'd60) begin
         f_val = (vb & vc) | (vb & vd) | (vc & vd);
         k_val = K_ROUND2;
      end else begin
         f_val = vb ^ vc ^ vd;
         k_val = K_ROUND3;
      end
   end

   assign temp = {va[26:0], va[31:27]} + f_val + ve + w_ff[0] + k_val;

   always_comb begin
      w_in = w_ff;
      if (cmd.round_en) begin
         for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[WINDOW_DEPTH-1] = w_next;
      end else if (cmd.wr_en) begin
         w_in[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] = wr_byte;
      end
   end

   always_comb begin
      vars_in  = vars_ff;
      chain_in = chain_ff;
      if (cmd.clear) begin
         for (int i = 0; i < CHAIN_DEPTH; i++) begin
            vars_in[i]  = '0;
            chain_in[i] = SHA1_IV[i];
         end
      end else begin
         if (cmd.vars_load) begin
            vars_in = chain_ff;
         end else if (cmd.round_en) begin
            vars_in[0] = temp;
            vars_in[1] = va;
            vars_in[2] = {vb[1:0], vb[31:2]};
            vars_in[3] = vc;
            vars_in[4] = vd;
         end
         if (cmd.chain_add) begin
            for (int i = 0; i < CHAIN_DEPTH; i++) begin
               chain_in[i] = chain_ff[i] + vars_ff[i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      pad_in   = pad_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      if (cmd.clear) begin
         count_in = '0;
         idx_in   = '0;
      end else begin
         if (cmd.cnt_inc) count_in = count_ff + 61'd1;
         if (cmd.out_next) idx_in = idx_ff + 3'd1;
      end
      if (cmd.pad_set) begin
         pad_in = count_ff[5:0] + 6'd1;
      end else if (cmd.pad_inc) begin
         pad_in = pad_ff + 6'd1;
      end
      if (cmd.vars_load) begin
         round_in = '0;
      end else if (cmd.round_en && (round_ff != ROUND_LAST)) begin
         round_in = round_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHAIN_DEPTH; i++) begin
            vars_ff[i]  <= '0;
            chain_ff[i] <= SHA1_IV[i];
         end
         count_ff <= '0;
         pad_ff   <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
      end else begin
         vars_ff  <= vars_in;
         chain_ff <= chain_in;
         count_ff <= count_in;
         pad_ff   <= pad_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
      end
   end

   assign sts.cnt_pos_last = (count_ff[5:0] == BLOCK_LAST_POS);
   assign sts.pad_pos_last = (pad_ff == BLOCK_LAST_POS);
   assign sts.pad_at_len   = (pad_ff == LEN_POS);
   assign sts.round_last   = (round_ff == ROUND_LAST);
   assign sts.word_last    = (idx_ff == WORD_LAST);

   assign out_word  = chain_ff[idx_ff];
   assign out_index = idx_ff;

   round_range: assert property (@(posedge clock) disable iff (reset)
      round_ff <= ROUND_LAST)
      else $error("round counter out of range");

   index_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= WORD_LAST)
      else $error("digest word index out of range");

   clear_count: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (count_ff == '0) && (idx_ff == '0))
      else $error("clear did not reset byte count and word index");

endmodule

`default_nettype wire

/* src/sha1_ctrl.sv */
`default_nettype none

module sha1_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic                  in_present,
   input  wire logic                  in_end,
   output logic                       in_ready,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   input  wire sha1_pkg::sha1_sts_type sts,
   output sha1_pkg::sha1_cmd_type     cmd
);
   import sha1_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MARK  = 3'd1;
   localparam logic [2:0] S_ZERO  = 3'd2;
   localparam logic [2:0] S_LEN   = 3'd3;
   localparam logic [2:0] S_LOAD  = 3'd4;
   localparam logic [2:0] S_ROUND = 3'd5;
   localparam logic [2:0] S_ADD   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               if (in_present) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_src  = SRC_MSG;
                  cmd.cnt_inc = 1'b1;
               end
               if (in_present && sts.cnt_pos_last) begin
                  state_in = S_LOAD;
                  ret_in   = in_end ? S_MARK : S_IDLE;
               end else if (in_end) begin
                  state_in = S_MARK;
               end
            end
         end
         S_MARK: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_src  = SRC_MARK;
            cmd.pad_set = 1'b1;
            if (sts.cnt_pos_last) begin
               state_in = S_LOAD;
               ret_in   = S_ZERO;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            if (sts.pad_at_len) begin
               state_in = S_LEN;
            end else begin
               cmd.wr_en     = 1'b1;
               cmd.wr_src    = SRC_ZERO;
               cmd.wr_at_pad = 1'b1;
               cmd.pad_inc   = 1'b1;
               if (sts.pad_pos_last) begin
                  state_in = S_LOAD;
                  ret_in   = S_ZERO;
               end
            end
         end
         S_LEN: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_src    = SRC_LEN;
            cmd.wr_at_pad = 1'b1;
            cmd.pad_inc   = 1'b1;
            if (sts.pad_pos_last) begin
               state_in = S_LOAD;
               ret_in   = S_OUT;
            end
         end
         S_LOAD: begin
            cmd.vars_load = 1'b1;
            state_in      = S_ROUND;
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            if (sts.round_last) state_in = S_ADD;
         end
         S_ADD: begin
            cmd.chain_add = 1'b1;
            state_in      = ret_ff;
         end
         S_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               cmd.out_next = 1'b1;
               if (sts.word_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   round_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) && sts.round_last |=> (state_ff == S_ADD))
      else $error("round loop did not end after the last round");

   len_from_pad: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LEN) && sts.pad_pos_last |=> (state_ff == S_LOAD))
      else $error("length field did not close a block");

   ret_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD) |-> (ret_ff == S_IDLE || ret_ff == S_MARK ||
                               ret_ff == S_ZERO || ret_ff == S_OUT))
      else $error("bad return state after compression");

endmodule

`default_nettype wire

/* src/sha1_hash_engine.sv */
// channel  dir  signals                         contents
// req      in   req_tvalid/tready/tdata/tuser   tdata: data_byte[7:0]
//                 /tlast                        tuser: byte_present, tlast: message_end
// rsp      out  rsp_tvalid/tready/tdata/tuser   tdata: digest_word[31:0]
//                 /tlast                        tuser: word_index[2:0], tlast: digest_last
//
// byte transfers within a block are accepted back to back; the byte that fills a
// 64-byte block starts the compression (load, 80 rounds, chain add)
// an end transfer then writes the marker byte, the zero bytes and the length field,
// with one or two more compressions, and presents the five digest words from the
// chain registers, one per rsp transfer
// reset is synchronous and restores the initial vector and a zero byte count;
// req_tready stays low while a block compresses or a digest waits on rsp_tready
`default_nettype none

module sha1_hash_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tuser,   // byte_present
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // digest_word
   output logic [2:0]       rsp_tuser,   // word_index
   output logic             rsp_tlast
);
   import sha1_pkg::*;

   sha1_cmd_type cmd;
   sha1_sts_type sts;

   sha1_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_present (req_tuser),
      .in_end     (req_tlast),
      .in_ready   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sha1_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_byte   (req_tdata),
      .out_word  (rsp_tdata),
      .out_index (rsp_tuser)
   );

   assign rsp_tlast = sts.word_last;

   no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a digest is pending");

   last_marks_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == WORD_LAST)))
      else $error("tlast does not match the final word index");

   back_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("engine not ready after the digest was sent");

   words_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("digest words not presented back to back");

endmodule

`default_nettype wire

/* tb/sv/sha1_hash_engine_tb.sv */
`timescale 1ns / 100ps

module sha1_hash_engine_tb;

   import sha1_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 180;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_entry_type;

   class digest_scoreboard;
      logic [31:0]      chain [CHAIN_DEPTH];
      logic [31:0]      block_words [WINDOW_DEPTH];
      logic [60:0]      msg_bytes;
      digest_entry_type pending [$];
      int               errors;
      int               words_checked;
      int               digests_done;

      function new();
         restart();
         errors = 0;
         words_checked = 0;
         digests_done = 0;
      endfunction

      function void restart();
         for (int i = 0; i < CHAIN_DEPTH; i++) chain[i] = SHA1_IV[i];
         for (int i = 0; i < WINDOW_DEPTH; i++) block_words[i] = '0;
         msg_bytes = '0;
      endfunction

      function logic [31:0] rol(logic [31:0] v, int n);
         return (v << n) | (v >> (32 - n));
      endfunction

      // 80-round compression of the packed block into the chain value
      function void absorb_block();
         logic [31:0] w [WINDOW_DEPTH];
         logic [31:0] a, b, c, d, e, f, k, wt, t;
         w = block_words;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int r = 0; r < ROUND_COUNT; r++) begin
            if (r < 16) begin
               wt = w[r];
            end else begin
               wt = rol(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16], 1);
               w[r % 16] = wt;
            end
            if (r < 20) begin
               f = (b & c) | (~b & d);
               k = K_ROUND0;
            end else if (r < 40) begin
               f = b ^ c ^ d;
               k = K_ROUND1;
            end else if (r < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = K_ROUND2;
            end else begin
               f = b ^ c ^ d;
               k = K_ROUND3;
            end
            t = rol(a, 5) + f + e + wt + k;
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      function void place_byte(logic [5:0] pos, logic [7:0] value);
         logic [3:0] wi;
         wi = pos[5:2];
         if (pos[1:0] == 2'd0) block_words[wi] = '0;
         block_words[wi][8 * (3 - int'(pos[1:0])) +: 8] = value;
         if (pos == BLOCK_LAST_POS) absorb_block();
      endfunction

      function void note_req(logic [7:0] data, logic present, logic last);
         logic [5:0]       pos;
         logic [63:0]      bit_len;
         digest_entry_type entry;
         if (present) begin
            place_byte(msg_bytes[5:0], data);
            msg_bytes++;
         end
         if (!last) return;
         // padding: marker, zeros up to the length field, 64-bit bit length
         pos = msg_bytes[5:0];
         place_byte(pos, 8'h80);
         pos++;
         while (pos != LEN_POS) begin
            place_byte(pos, 8'h00);
            pos++;
         end
         bit_len = {msg_bytes, 3'b000};
         for (int i = 0; i < 8; i++) begin
            place_byte(pos, bit_len[8 * (7 - i) +: 8]);
            pos++;
         end
         for (int i = 0; i < CHAIN_DEPTH; i++) begin
            entry.word  = chain[i];
            entry.index = 3'(i);
            entry.last  = (3'(i) == WORD_LAST);
            pending = {pending, entry};
         end
         restart();
      endfunction

      function void check_word(logic [31:0] word, logic [2:0] index, logic last);
         digest_entry_type want;
         if (pending.size() == 0) begin
            $error("unexpected digest word %h index %0d", word, index);
            errors++;
            return;
         end
         want = pending.pop_front();
         words_checked++;
         if (word !== want.word) begin
            $error("digest_word expected %h actual %h", want.word, word);
            errors++;
         end
         if (index !== want.index) begin
            $error("word_index expected %0d actual %0d", want.index, index);
            errors++;
         end
         if (last !== want.last) begin
            $error("digest_last expected %0b actual %0b", want.last, last);
            errors++;
         end
         if (want.last) digests_done++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // data_byte
   logic        req_tuser = 1'b0;    // byte_present
   logic        req_tlast = 1'b0;    // message_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // digest_word
   logic [2:0]  rsp_tuser;           // word_index
   logic        rsp_tlast;           // digest_last

   digest_scoreboard sb;
   int               cycles = 0;
   int               msg_items = 0;
   int               idle_items = 0;
   int               messages = 0;
   logic             held_long = 1'b0;

   sha1_hash_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL sha1_hash_engine");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int next_gap(logic burst);
      return burst ? 0 : idle_len();
   endfunction

   task automatic send_item(logic [7:0] data, logic present, logic last, int gap);
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= present;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_req(data, present, last);
      if (present || last) msg_items++;
      else idle_items++;
      if (last) messages++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
   endtask

   task automatic send_message(int len);
      logic burst;
      logic carry_end;
      burst = ($urandom_range(0, 3) == 0);
      carry_end = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 8) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, next_gap(burst));
         end
         send_item(8'($urandom_range(0, 255)), 1'b1, carry_end && (i == len - 1),
                   next_gap(burst));
      end
      if (!carry_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, next_gap(burst));
   endtask

   // receiver: random stalls and one long hold-off of rsp_tready
   initial begin
      int stall;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!held_long && sb.words_checked >= 25) begin
            held_long = 1'b1;
            rsp_tready <= 1'b0;
            repeat (480) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            stall = idle_len();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      int boundary_len [3];
      int len;
      int msg_no;
      boundary_len = '{56, 64, 55};
      msg_no = 0;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // idle, empty message, end carrying a byte, end without a byte
      send_item(8'hFF, 1'b0, 1'b0, idle_len());
      send_item(8'hFF, 1'b0, 1'b1, idle_len());
      send_item(8'h00, 1'b1, 1'b0, 0);
      send_item(8'hFF, 1'b1, 1'b0, 0);
      send_item(8'hA5, 1'b1, 1'b1, idle_len());
      send_item(8'h5A, 1'b1, 1'b1, idle_len());
      send_item(8'h80, 1'b1, 1'b0, idle_len());
      send_item(8'h3C, 1'b0, 1'b0, 0);
      send_item(8'h7F, 1'b1, 1'b0, idle_len());
      send_item(8'h00, 1'b0, 1'b1, idle_len());
      wait_idle();

      while (msg_items < RANDOM_ITEMS - 20) begin
         if (msg_no % 3 == 2) len = boundary_len[(msg_no / 3) % 3];
         else if ($urandom_range(0, 9) < 7) len = $urandom_range(0, 8);
         else len = $urandom_range(9, 20);
         send_message(len);
         msg_no++;
         if (msg_no == 5) wait_idle();
      end

      wait_idle();
      repeat (200) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $error("%0d digest words never arrived", sb.pending.size());
         sb.errors++;
      end
      $display("run covered %0d messages from %0d byte/end transfers and %0d idle transfers",
               messages, msg_items, idle_items);
      $display("%0d digests and %0d digest words checked", sb.digests_done, sb.words_checked);
      if (sb.errors == 0) begin
         $display("PASS sha1_hash_engine");
      end else begin
         $display("FAIL sha1_hash_engine");
      end
      $finish;
   end

endmodule

/* sim.f */
src/sha1_pkg.sv
src/sha1_dp.sv
src/sha1_ctrl.sv
src/sha1_hash_engine.sv
tb/sv/sha1_hash_engine_tb.sv
